// ----- src/positional_array_list_top_macros.svh -----
// Assertion macros used by the positional array list top level.
`ifndef POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PAL_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PAL_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent is followed by a consequent.
`define PAL_LATER2(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// ----- src/pal_pkg.sv -----
// Types and constants shared by the positional array list modules.
package pal_pkg;

   localparam int CAPACITY = 64;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 7;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_SET    = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      op_type                     operation;
      logic [POS_W-1:0]           position;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  read_value;
      status_type                 status;
      logic [COUNT_W-1:0]         count;
      logic                       is_empty;
      logic                       is_full;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                       go;
      op_type                     op;
      logic [POS_W-1:0]           pos_idx;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

// ----- src/pal_cell.sv -----
// One storage cell of the list row: holds one entry and shifts with its neighbours.
module pal_cell (
   input  logic                               clock,
   input  pal_pkg::cmd_type                   cmd,
   input  logic [pal_pkg::POS_W-1:0]          idx,
   input  logic signed [pal_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [pal_pkg::VALUE_W-1:0] right_entry,
   output logic signed [pal_pkg::VALUE_W-1:0] entry,
   output logic signed [pal_pkg::VALUE_W-1:0] tap
);

   logic signed [pal_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic signed [pal_pkg::VALUE_W-1:0] tap_ff, tap_in;
   logic hit, above;

   assign hit   = cmd.go && (idx == cmd.pos_idx);
   assign above = cmd.go && (idx > cmd.pos_idx);

   always_comb begin
      entry_in = entry_ff;
      tap_in   = '0;
      unique case (cmd.op)
         pal_pkg::OP_GET: begin
            if (hit) tap_in = entry_ff;
         end
         pal_pkg::OP_SET: begin
            if (hit) entry_in = cmd.value;
         end
         pal_pkg::OP_INSERT: begin
            // take the new word at the slot, shift up above it
            if (hit) entry_in = cmd.value;
            else if (above) entry_in = left_entry;
         end
         pal_pkg::OP_REMOVE: begin
            // close the gap: pull from the right neighbour
            if (hit || above) entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule

// ----- src/positional_array_list_top.sv -----
// Top level of the positional array list: command check, cell row and result stage.
//
//   channel   direction  handshake             payload
//   req_      in         start / busy          req_word  (pal_pkg::req_type)
//   rsp_      out        rsp_strobe, 1 cycle   rsp_word  (pal_pkg::rsp_type)
//
// A word is taken at each edge with start high and busy low; busy stays low,
// so one word per cycle is taken and every operation finishes its shift at the
// accepting edge, since each cell moves its entry to a neighbour at that edge.
// After acceptance the result is registered in the cell read taps, then ORed
// into the result register.
// Synchronous active-high reset clears the count and the strobes; entries are
// left undefined until written. The receiver cannot stall the result.
`include "positional_array_list_top_macros.svh"

module positional_array_list_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pal_pkg::req_type req_word,
   output logic             rsp_strobe,
   output pal_pkg::rsp_type rsp_word
);

   logic accept;
   logic [pal_pkg::CNT_W-1:0] count_ff, count_in;
   logic [pal_pkg::POS_W-1:0] n_ext;
   logic pos_nz, pos_in_n, pos_in_n1;
   logic ok;
   pal_pkg::status_type status_c;
   pal_pkg::cmd_type cmd;

   logic s1_valid_ff;
   pal_pkg::status_type s1_status_ff;

   logic rsp_strobe_ff;
   pal_pkg::rsp_type rsp_word_ff, rsp_word_in;
   logic signed [pal_pkg::VALUE_W-1:0] read_or;

   logic signed [pal_pkg::VALUE_W-1:0] entries [pal_pkg::CAPACITY];
   logic signed [pal_pkg::VALUE_W-1:0] taps    [pal_pkg::CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // position checks against the count before this word
   assign n_ext     = pal_pkg::POS_W'(count_ff);
   assign pos_nz    = (req_word.position != '0);
   assign pos_in_n  = pos_nz && (req_word.position <= n_ext);
   assign pos_in_n1 = pos_nz && (req_word.position <= (n_ext + pal_pkg::POS_W'(1)));

   always_comb begin
      status_c = pal_pkg::ST_OK;
      count_in = count_ff;
      unique case (req_word.operation)
         pal_pkg::OP_GET, pal_pkg::OP_SET: begin
            if (!pos_in_n) status_c = pal_pkg::ST_BAD_POS;
         end
         pal_pkg::OP_INSERT: begin
            // full before position
            priority if (count_ff == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
               status_c = pal_pkg::ST_FULL;
            end else if (!pos_in_n1) begin
               status_c = pal_pkg::ST_BAD_POS;
            end else begin
               count_in = count_ff + pal_pkg::CNT_W'(1);
            end
         end
         pal_pkg::OP_REMOVE: begin
            // empty before position
            priority if (count_ff == '0) begin
               status_c = pal_pkg::ST_EMPTY;
            end else if (!pos_in_n) begin
               status_c = pal_pkg::ST_BAD_POS;
            end else begin
               count_in = count_ff - pal_pkg::CNT_W'(1);
            end
         end
         default: begin
            status_c = pal_pkg::ST_OK;
         end
      endcase
   end

   assign ok = accept && (status_c == pal_pkg::ST_OK);

   // broadcast the checked command along the row
   always_comb begin
      cmd.go      = ok;
      cmd.op      = req_word.operation;
      cmd.pos_idx = req_word.position - pal_pkg::POS_W'(1);
      cmd.value   = req_word.value;
   end

   // row of cells; each end sees the broadcast word or zero past the last cell
   for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         if (pal_pkg::CAPACITY == 1) begin : g_only
            pal_cell u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .idx         (pal_pkg::POS_W'(i)),
               .left_entry  (req_word.value),
               .right_entry ('0),
               .entry       (entries[i]),
               .tap         (taps[i])
            );
         end else begin : g_head
            pal_cell u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .idx         (pal_pkg::POS_W'(i)),
               .left_entry  (req_word.value),
               .right_entry (entries[i+1]),
               .entry       (entries[i]),
               .tap         (taps[i])
            );
         end
      end else if (i == pal_pkg::CAPACITY - 1) begin : g_last
         pal_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .idx         (pal_pkg::POS_W'(i)),
            .left_entry  (entries[i-1]),
            .right_entry ('0),
            .entry       (entries[i]),
            .tap         (taps[i])
         );
      end else begin : g_mid
         pal_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .idx         (pal_pkg::POS_W'(i)),
            .left_entry  (entries[i-1]),
            .right_entry (entries[i+1]),
            .entry       (entries[i]),
            .tap         (taps[i])
         );
      end
   end

   // hold count and the first result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) count_ff <= count_in;
         s1_valid_ff <= accept;
      end
      s1_status_ff <= status_c;
   end

   // at most one cell tap is non-zero: OR them together
   always_comb begin
      read_or = '0;
      for (int k = 0; k < pal_pkg::CAPACITY; k++) begin
         read_or = read_or | taps[k];
      end
   end

   always_comb begin
      rsp_word_in.read_value = read_or;
      rsp_word_in.status     = s1_status_ff;
      rsp_word_in.count      = pal_pkg::COUNT_W'(count_ff);
      rsp_word_in.is_empty   = (count_ff == '0);
      rsp_word_in.is_full    = (count_ff == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
   end

   // advance to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   `PAL_LATER2(a_word_answered, accept, rsp_strobe, "accepted word produced no result")
   `PAL_CHECK(a_count_bound, count_ff <= pal_pkg::CNT_W'(pal_pkg::CAPACITY), "count above capacity")
   `PAL_IMPLY(a_full_status, rsp_strobe && (rsp_word.status == pal_pkg::ST_FULL), rsp_word.is_full, "full status on a list that is not full")
   `PAL_IMPLY(a_empty_status, rsp_strobe && (rsp_word.status == pal_pkg::ST_EMPTY), rsp_word.is_empty, "empty status on a list that is not empty")

endmodule
